// ===== rtl/core/pts_pkg.sv =====
// Package for the periodic timer scheduler: widths, status codes, sequencer states.
// No dependencies.
package pts_pkg;
   localparam int TIMER_SLOTS_DEF = 64;
   localparam int MAX_FIRES_DEF   = 32;
   localparam int TIME_W = 48;
   localparam int ID_W   = 16;
   localparam int INT_W  = 20;
   localparam int DLY_W  = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [9:0]  US_PER_MS = 10'd1000;
   localparam logic [19:0] US_PER_S  = 20'd1000000;

   typedef enum logic [1:0] {
      ST_FIRED = 2'd0,
      ST_IDLE  = 2'd1,
      ST_REG   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CMD_REGISTER = 1'b0,
      CMD_TICK     = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_WRITE,
      S_SCAN,
      S_CHECK,
      S_UPDATE,
      S_OUT
   } state_type;
endpackage

// ===== rtl/core/pts_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== rtl/core/periodic_timer_scheduler.sv =====
// Periodic timer scheduler top level: sequencer, one shared multiplier and
// adder, and timer slot RAM. Depends on pts_pkg and pts_ram.
//
// Input channel req_*: command 0 registers a timer (deadline = now + delay s),
// command 1 is a tick that fires every timer with deadline strictly before
// now, earliest first, ties by ascending id, at most MAX_FIRES per tick.
// Result channel rsp_*: status, fired_id and last; last marks the final item
// for each input. A register gives one item after the S_MUL and S_WRITE
// states; a full table answers in the cycle after the request is accepted.
// A tick runs a linear scan over the slot RAM for each fire, then S_CHECK
// and S_UPDATE for the deadline update; the scan reads one slot at a time
// over the single RAM port. A fired id is held until the next scan shows
// whether it is the last one. A tick ends with one more scan and check,
// or through S_OUT after its MAX_FIRES-th fire.
// The block takes one item at a time; req_stall stays high until the last
// result of the current item has been taken.
// Reset clears the timer count and sequencer; slot contents stay unknown.
// When rsp_stall is high the result holds; S_CHECK and S_OUT wait, the scan goes on.
module periodic_timer_scheduler
   import pts_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
   parameter int MAX_FIRES   = MAX_FIRES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [ID_W-1:0]   req_timer_id,
   input  logic [INT_W-1:0]  req_interval_ms,
   input  logic [DLY_W-1:0]  req_first_delay_s,
   input  logic [TIME_W-1:0] req_now_us,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_fired_id,
   output logic              rsp_last
);
   localparam int AW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int FW = $clog2(MAX_FIRES + 1);
   localparam int RW = TIME_W + INT_W + ID_W;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] best_ff, best_in;
   logic          have_ff, have_in;
   logic [TIME_W-1:0] bdl_ff, bdl_in;
   logic [ID_W-1:0]   bid_ff, bid_in;
   logic [INT_W-1:0]  bint_ff, bint_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [FW-1:0] fires_ff, fires_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [INT_W-1:0]  int_ff, int_in;
   logic [DLY_W-1:0]  dly_ff, dly_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] prod_ff, prod_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic          rl_ff, rl_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic [TIME_W-1:0] rdl;
   logic [INT_W-1:0]  rint;
   logic [ID_W-1:0]   rid;

   // shared unit: one multiply feeding a saturating add
   logic [INT_W-1:0]   mul_a;
   logic [INT_W-1:0]   mul_b;
   logic [2*INT_W-1:0] mul_p;
   logic [TIME_W-1:0] add_a;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] sat;

   assign {rdl, rint, rid} = ram_rdata;
   assign mul_p = mul_a * mul_b;
   assign sum = {1'b0, add_a} + {1'b0, prod_ff};
   assign sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

   pts_ram #(.WIDTH(RW), .DEPTH(TIMER_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign req_stall    = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid    = rv_ff;
   assign rsp_status   = rs_ff;
   assign rsp_fired_id = rid_ff;
   assign rsp_last     = rl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         rd_pend_ff <= rd_pend_in;
      end
      idx_ff <= idx_in;   best_ff <= best_in;   have_ff <= have_in;
      bdl_ff <= bdl_in;   bid_ff <= bid_in;     bint_ff <= bint_in;
      fires_ff <= fires_in; pid_ff <= pid_in;   id_ff <= id_in;
      int_ff <= int_in;   dly_ff <= dly_in;     now_ff <= now_in;
      prod_ff <= prod_in; rs_ff <= rs_in;       rid_ff <= rid_in;
      rl_ff <= rl_in;     rd_addr_ff <= rd_addr_in;
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  idx_in = idx_ff;
      best_in = best_ff;    have_in = have_ff;    bdl_in = bdl_ff;
      bid_in = bid_ff;      bint_in = bint_ff;    fires_in = fires_ff;
      pid_in = pid_ff;      id_in = id_ff;        int_in = int_ff;
      dly_in = dly_ff;      now_in = now_ff;      prod_in = prod_ff;
      rv_in = rv_ff;        rs_in = rs_ff;        rid_in = rid_ff;
      rl_in = rl_ff;        rd_pend_in = 1'b0;    rd_addr_in = rd_addr_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff[AW-1:0];
      ram_wdata = {sat, int_ff, id_ff};
      mul_a = {{(INT_W-DLY_W){1'b0}}, dly_ff};
      mul_b = US_PER_S;
      add_a = now_ff;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               id_in  = req_timer_id;
               int_in = (req_interval_ms == '0) ? INT_W'(1) : req_interval_ms;
               dly_in = req_first_delay_s;
               now_in = req_now_us;
               fires_in = '0;
               if (req_command == CMD_REGISTER) begin
                  if (count_ff >= CW'(TIMER_SLOTS)) begin
                     rv_in = 1'b1; rs_in = ST_FULL; rid_in = '0; rl_in = 1'b1;
                  end else begin
                     state_in = S_MUL;
                  end
               end else begin
                  state_in = S_SCAN;
                  idx_in = '0;
                  have_in = 1'b0;
               end
            end
         end
         S_MUL: begin
            prod_in  = {{(TIME_W-2*INT_W){1'b0}}, mul_p};
            state_in = S_WRITE;
         end
         S_WRITE: begin
            ram_addr = count_ff[AW-1:0];
            ram_we   = 1'b1;
            count_in = count_ff + CW'(1);
            rv_in = 1'b1; rs_in = ST_REG; rid_in = '0; rl_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // compare the entry read last cycle, issue the next read
            if (rd_pend_ff) begin
               if (!have_ff || rdl < bdl_ff || (rdl == bdl_ff && rid < bid_ff)) begin
                  have_in = 1'b1;
                  best_in = rd_addr_ff;
                  bdl_in = rdl; bid_in = rid; bint_in = rint;
               end
            end
            if (idx_ff < count_ff) begin
               ram_addr = idx_ff[AW-1:0];
               rd_pend_in = 1'b1;
               rd_addr_in = idx_ff[AW-1:0];
               idx_in = idx_ff + CW'(1);
            end else if (!rd_pend_ff) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!rv_ff || !rsp_stall) begin
               if (have_ff && bdl_ff < now_ff) begin
                  // another fire follows, so the held id is not the last
                  if (fires_ff != '0) begin
                     rv_in = 1'b1; rs_in = ST_FIRED; rid_in = pid_ff; rl_in = 1'b0;
                  end
                  pid_in = bid_ff;
                  fires_in = fires_ff + FW'(1);
                  state_in = S_UPDATE;
                  mul_a = bint_ff;
                  mul_b = {10'd0, US_PER_MS};
                  prod_in = {{(TIME_W-2*INT_W){1'b0}}, mul_p};
               end else if (fires_ff == '0) begin
                  rv_in = 1'b1; rs_in = ST_IDLE; rid_in = '0; rl_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rv_in = 1'b1; rs_in = ST_FIRED; rid_in = pid_ff; rl_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_UPDATE: begin
            add_a = bdl_ff;
            ram_addr = best_ff;
            ram_we = 1'b1;
            ram_wdata = {sat, bint_ff, bid_ff};
            if (fires_ff == FW'(MAX_FIRES)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SCAN;
               idx_in = '0;
               have_in = 1'b0;
            end
         end
         S_OUT: begin
            // fire limit reached: send the held id as final
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; rs_in = ST_FIRED; rid_in = pid_ff; rl_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== bench/tb.sv =====
// Testbench for periodic_timer_scheduler: directed and random register/tick items,
// a scoreboard class that predicts fired ids and checks every result item.
// Depends on pts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb
   import pts_pkg::*;
();

   localparam int SLOTS     = TIMER_SLOTS_DEF;
   localparam int FIRES     = MAX_FIRES_DEF;
   localparam int IDLE_LIMIT = 5000;

   class timer_scoreboard;
      typedef struct {
         status_type  status;
         logic [15:0] fired_id;
         logic        last;
      } outcome_type;

      outcome_type  pending_q[$];
      logic [47:0]  deadline[SLOTS];
      logic [19:0]  interval[SLOTS];
      logic [15:0]  ident[SLOTS];
      int unsigned  count;
      int unsigned  errors;

      function void clear();
         count = 0;
         errors = 0;
         pending_q.delete();
      endfunction

      function logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
         logic [63:0] s;
         s = {16'd0, a} + b;
         return (s > {16'd0, TIME_MAX}) ? TIME_MAX : s[47:0];
      endfunction

      function void push(status_type st, logic [15:0] id, logic last);
         outcome_type o;
         o.status = st;
         o.fired_id = id;
         o.last = last;
         pending_q.insert(pending_q.size(), o);
      endfunction

      // Predict the results of one accepted item.
      function void note_item(command_type cmd, logic [15:0] id, logic [19:0] ivl,
                              logic [15:0] dly, logic [47:0] now);
         int fired;
         int best;
         if (cmd == CMD_REGISTER) begin
            if (count >= SLOTS) begin
               push(ST_FULL, 16'd0, 1'b1);
               return;
            end
            ident[count] = id;
            interval[count] = (ivl == 0) ? 20'd1 : ivl;
            deadline[count] = add_sat(now, 64'(dly) * 64'd1000000);
            count++;
            push(ST_REG, 16'd0, 1'b1);
            return;
         end
         fired = 0;
         while (fired < FIRES) begin
            best = -1;
            for (int i = 0; i < count; i++)
               if (best < 0 || deadline[i] < deadline[best] ||
                   (deadline[i] == deadline[best] && ident[i] < ident[best]))
                  best = i;
            if (best < 0 || !(deadline[best] < now))
               break;
            push(ST_FIRED, ident[best], 1'b0);
            fired++;
            deadline[best] = add_sat(deadline[best], 64'(interval[best]) * 64'd1000);
         end
         if (fired == 0)
            push(ST_IDLE, 16'd0, 1'b1);
         else
            pending_q[pending_q.size()-1].last = 1'b1;
      endfunction

      function void check_result(logic [1:0] st, logic [15:0] id, logic last);
         outcome_type o;
         if (pending_q.size() == 0) begin
            $display("%0t: expected no result, actual status=%0d id=%0h last=%0b",
                     $time, st, id, last);
            errors++;
            return;
         end
         o = pending_q.pop_front();
         if (st !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, st);
            errors++;
         end
         if (id !== o.fired_id) begin
            $display("%0t: fired_id expected %0h actual %0h", $time, o.fired_id, id);
            errors++;
         end
         if (last !== o.last) begin
            $display("%0t: last expected %0b actual %0b", $time, o.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [15:0] req_timer_id;
   logic [19:0] req_interval_ms;
   logic [15:0] req_first_delay_s;
   logic [47:0] req_now_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_fired_id;
   logic        rsp_last;

   timer_scoreboard sb;
   int unsigned hold_cycles;
   int unsigned idle_count;
   logic [47:0] now_t;

   periodic_timer_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_timer_id(req_timer_id),
      .req_interval_ms(req_interval_ms), .req_first_delay_s(req_first_delay_s),
      .req_now_us(req_now_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_fired_id(rsp_fired_id), .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) < 6)
         return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   task automatic send_item(command_type cmd, logic [15:0] id, logic [19:0] ivl,
                            logic [15:0] dly, logic [47:0] now);
      int unsigned gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_timer_id <= id;
      req_interval_ms <= ivl;
      req_first_delay_s <= dly;
      req_now_us <= now;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      sb.note_item(cmd, id, ivl, dly, now);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic register_random();
      logic [19:0] ivl;
      logic [15:0] dly;
      case ($urandom_range(0, 9))
         0: ivl = 20'd0;
         1: ivl = 20'($urandom);
         default: ivl = 20'($urandom_range(1, 500));
      endcase
      dly = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      send_item(CMD_REGISTER, 16'($urandom), ivl, dly, now_t);
   endtask

   // Receiver: random stalls and random hold-offs, or a long hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if ($urandom_range(0, 19) == 0) begin
            rsp_stall <= 1'b1;
            hold_cycles = $urandom_range(5, 30);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_fired_id, rsp_last);

   // Watchdog: cycles with nothing accepted on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      sb = new();
      sb.clear();
      hold_cycles = 0;
      idle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_timer_id = '0;
      req_interval_ms = '0;
      req_first_delay_s = '0;
      req_now_us = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick, zero interval, overflow, equal id and deadline.
      send_item(CMD_TICK, 16'd0, 20'd0, 16'd0, 48'd0);
      send_item(CMD_REGISTER, 16'hFFFF, 20'd0, 16'd0, 48'd0);
      send_item(CMD_REGISTER, 16'h0000, 20'hFFFFF, 16'hFFFF, TIME_MAX);
      send_item(CMD_REGISTER, 16'd5, 20'd1, 16'd0, 48'd100);
      send_item(CMD_REGISTER, 16'd5, 20'd3, 16'd0, 48'd100);
      send_item(CMD_REGISTER, 16'd3, 20'd2, 16'd0, 48'd100);
      send_item(CMD_TICK, 16'd0, 20'd0, 16'd0, 48'd100);
      send_item(CMD_TICK, 16'd0, 20'd0, 16'd0, 48'd101);
      send_item(CMD_TICK, 16'd0, 20'd0, 16'd0, 48'd4000);
      send_item(CMD_TICK, 16'd0, 20'd0, 16'd0, 48'd1000000);
      send_item(CMD_TICK, 16'hFFFF, 20'hFFFFF, 16'hFFFF, TIME_MAX);
      send_item(CMD_REGISTER, 16'h1234, 20'd1000000, 16'd1, TIME_MAX - 48'd5);

      now_t = 48'd2000000;
      for (int n = 0; n < 100; n++) begin
         if (n == 30) begin
            // Fill the table and push past it.
            while (sb.count < SLOTS)
               register_random();
            register_random();
            register_random();
         end
         if (n == 55)
            hold_cycles = 400;
         if (n == 80) begin
            req_valid <= 1'b0;
            while (sb.pending_q.size() != 0)
               @(posedge clock);
            repeat (100) @(posedge clock);
         end
         if ($urandom_range(0, 9) < 4) begin
            register_random();
         end else if ($urandom_range(0, 19) == 0) begin
            send_item(CMD_TICK, 16'($urandom), 20'($urandom), 16'($urandom),
                      {16'($urandom), 32'($urandom)});
         end else begin
            now_t = now_t + 48'($urandom_range(0, 300000));
            send_item(CMD_TICK, 16'($urandom), 20'($urandom), 16'($urandom), now_t);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
